### rtl/ats_pkg.sv
// Shared types and constants for the animation timeline sequencer.
// No dependencies; every other file imports this package.
package ats_pkg;

    localparam int unsigned DUR_W   = 16;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned PROG_W  = 17;
    localparam int unsigned REP_W   = 8;

    localparam logic [PROG_W-1:0] ONE_Q16 = 17'h10000;

    // floor(x / 1000) == (x * SEC_RECIP) >> SEC_SHIFT for any 32-bit x
    localparam logic [28:0] SEC_RECIP = 29'h10624DD3;
    localparam int unsigned SEC_SHIFT = 38;
    localparam int unsigned PROD_W    = 61;

    // configuration register indexes
    localparam logic [1:0] CFG_TIME_UNIT    = 2'd0;
    localparam logic [1:0] CFG_DURATION     = 2'd1;
    localparam logic [1:0] CFG_REPEAT_COUNT = 2'd2;
    localparam logic [1:0] CFG_AUTO_REVERSE = 2'd3;

    // time units
    localparam logic [1:0] TU_FRAMES = 2'd0;
    localparam logic [1:0] TU_MS     = 2'd1;

    // item operations
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // register reset values
    localparam logic [1:0]       TIME_UNIT_RST = TU_MS;
    localparam logic [DUR_W-1:0] DURATION_RST  = 16'd300;
    localparam logic [REP_W-1:0] REPEAT_RST    = 8'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_SEC,
        ST_CMP,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic diff;
        logic mul;
        logic sec;
        logic cmp;
        logic div_step;
        logic fin;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic short_item;   // start, or tick while finished: no timing math
        logic sec_unit;
        logic pass_end;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

### rtl/ats_if.sv
// Valid/ready channel interfaces: input items, result items, configuration writes.
// Depends on ats_pkg for field widths.
interface ats_in_if import ats_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               op;
    logic [STAMP_W-1:0] now_ms;

    modport source (output valid, op, now_ms, input ready);
    modport sink   (input valid, op, now_ms, output ready);
endinterface

interface ats_out_if import ats_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PROG_W-1:0] progress;
    logic              computed;
    logic              reversing;
    logic              finished;

    modport source (output valid, progress, computed, reversing, finished, input ready);
    modport sink   (input valid, progress, computed, reversing, finished, output ready);
endinterface

interface ats_cfg_if import ats_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       index;
    logic [DUR_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/ats_ctrl.sv
// Sequencing state machine of the timeline sequencer.
// Depends on ats_pkg; drives commands into ats_dp and reads its status.
module ats_ctrl import ats_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_stat.short_item ? ST_OUT : ST_DIFF;
                end
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state = i_stat.sec_unit ? ST_MUL : ST_CMP;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = ST_SEC;
            end
            ST_SEC: begin
                o_cmd.sec = 1'b1;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state = i_stat.pass_end ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/ats_dp.sv
// Datapath of the timeline sequencer: config registers, timeline state,
// elapsed-time unit, bit-serial divider and result register. Depends on ats_pkg.
module ats_dp import ats_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_op,
    input  logic [STAMP_W-1:0] i_now_ms,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [DUR_W-1:0]   i_cfg_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [PROG_W-1:0]  o_progress,
    output logic               o_computed,
    output logic               o_reversing,
    output logic               o_finished
);

    // configuration
    logic [1:0]       r_time_unit;
    logic [DUR_W-1:0] r_duration;
    logic [REP_W-1:0] r_repeat_count;
    logic             r_auto_reverse;

    // timeline state
    logic [STAMP_W-1:0] r_frame_count;
    logic [STAMP_W-1:0] r_origin_ms;
    logic [REP_W-1:0]   r_repeats_left;
    logic               r_restart_pending;
    logic               r_reverse;
    logic               r_finish;

    // working registers
    logic [STAMP_W-1:0] r_now;
    logic [STAMP_W-1:0] r_elapsed;
    logic [PROD_W-1:0]  r_prod;
    logic [DUR_W-1:0]   r_rem;
    logic [DUR_W-1:0]   r_quo;
    logic [3:0]         r_div_cnt;

    // result waiting for the output register
    logic [PROG_W-1:0] r_res_progress;
    logic              r_res_computed;
    logic              r_res_reversing;
    logic              r_res_finished;

    logic               r_out_valid;
    logic [PROG_W-1:0]  r_out_progress;
    logic               r_out_computed;
    logic               r_out_reversing;
    logic               r_out_finished;

    // end-of-pass next values
    logic             pass_end;
    logic             last_pass;
    logic [REP_W-1:0] n_repeats_left;
    logic             n_restart_pending;
    logic             n_reverse;
    logic             n_finish;

    logic [DUR_W:0]   div_shift;
    logic             div_ge;
    logic [DUR_W:0]   div_diff;
    logic [PROG_W-1:0] quo_prog;

    assign pass_end = (r_elapsed >= {{(STAMP_W-DUR_W){1'b0}}, r_duration});

    always_comb begin
        last_pass         = (r_repeats_left == REP_W'(1));
        n_repeats_left    = (r_repeats_left != '0) ? r_repeats_left - REP_W'(1)
                                                   : r_repeats_left;
        n_restart_pending = r_restart_pending;
        n_reverse         = r_reverse;
        n_finish          = r_finish;
        if (r_auto_reverse) begin
            n_restart_pending = 1'b1;
            if (r_reverse) begin
                n_reverse = 1'b0;
                if (last_pass) begin
                    n_finish = 1'b1;
                end
            end else begin
                n_reverse      = 1'b1;
                n_repeats_left = r_repeats_left;  // forward half does not count
            end
        end else if (last_pass) begin
            n_finish = 1'b1;
        end else begin
            n_restart_pending = 1'b1;
        end
    end

    // restoring divide: remainder stays below duration
    assign div_shift = {r_rem, 1'b0};
    assign div_ge    = (div_shift >= {1'b0, r_duration});
    assign div_diff  = div_shift - {1'b0, r_duration};
    assign quo_prog  = {1'b0, r_quo};

    always_comb begin
        o_stat.short_item = (i_op == OP_START) || (r_finish && !r_restart_pending);
        o_stat.sec_unit   = r_time_unit[1];
        o_stat.pass_end   = pass_end;
        o_stat.div_last   = (r_div_cnt == 4'hF);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_unit       <= TIME_UNIT_RST;
            r_duration        <= DURATION_RST;
            r_repeat_count    <= REPEAT_RST;
            r_auto_reverse    <= 1'b0;
            r_frame_count     <= '0;
            r_origin_ms       <= '0;
            r_repeats_left    <= REPEAT_RST;
            r_restart_pending <= 1'b0;
            r_reverse         <= 1'b0;
            r_finish          <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TIME_UNIT:    r_time_unit    <= i_cfg_data[1:0];
                    CFG_DURATION:     r_duration     <= i_cfg_data;
                    CFG_REPEAT_COUNT: r_repeat_count <= i_cfg_data[REP_W-1:0];
                    CFG_AUTO_REVERSE: r_auto_reverse <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                if (i_op == OP_START) begin
                    r_frame_count     <= '0;
                    r_origin_ms       <= i_now_ms;
                    r_repeats_left    <= r_repeat_count;
                    r_restart_pending <= 1'b0;
                    r_reverse         <= 1'b0;
                    r_finish          <= 1'b0;
                end else if (r_restart_pending) begin
                    r_restart_pending <= 1'b0;
                    r_frame_count     <= STAMP_W'(1);
                    r_origin_ms       <= i_now_ms;
                end else if (!r_finish) begin
                    r_frame_count <= r_frame_count + STAMP_W'(1);
                end
            end
            if (i_cmd.cmp && pass_end) begin
                r_repeats_left    <= n_repeats_left;
                r_restart_pending <= n_restart_pending;
                r_reverse         <= n_reverse;
                r_finish          <= n_finish;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_now <= i_now_ms;
            // short items finish here; ticks overwrite the result later
            r_res_progress  <= '0;
            r_res_computed  <= 1'b0;
            r_res_reversing <= (i_op == OP_START) ? 1'b0 : r_reverse;
            r_res_finished  <= (i_op != OP_START);
        end
        if (i_cmd.diff) begin
            r_elapsed <= (r_time_unit == TU_FRAMES) ? r_frame_count : r_now - r_origin_ms;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_elapsed) * PROD_W'(SEC_RECIP);
        end
        if (i_cmd.sec) begin
            r_elapsed <= STAMP_W'(r_prod[PROD_W-1:SEC_SHIFT]);
        end
        if (i_cmd.cmp) begin
            r_rem     <= r_elapsed[DUR_W-1:0];
            r_quo     <= '0;
            r_div_cnt <= '0;
            if (pass_end) begin
                r_res_progress  <= r_reverse ? '0 : ONE_Q16;
                r_res_computed  <= 1'b1;
                r_res_reversing <= n_reverse;
                r_res_finished  <= n_finish;
            end
        end
        if (i_cmd.div_step) begin
            r_rem     <= div_ge ? div_diff[DUR_W-1:0] : div_shift[DUR_W-1:0];
            r_quo     <= {r_quo[DUR_W-2:0], div_ge};
            r_div_cnt <= r_div_cnt + 4'd1;
        end
        if (i_cmd.fin) begin
            r_res_progress  <= r_reverse ? ONE_Q16 - quo_prog : quo_prog;
            r_res_computed  <= 1'b1;
            r_res_reversing <= r_reverse;
            r_res_finished  <= r_finish;
        end
        if (i_cmd.load_out) begin
            r_out_progress  <= r_res_progress;
            r_out_computed  <= r_res_computed;
            r_out_reversing <= r_res_reversing;
            r_out_finished  <= r_res_finished;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_progress  = r_out_progress;
    assign o_computed  = r_out_computed;
    assign o_reversing = r_out_reversing;
    assign o_finished  = r_out_finished;

endmodule

### rtl/animation_timeline_sequencer_core.sv
// Animation timeline sequencer: one result item per start or tick item, with
// progress in Q1.16, repeat counting and auto-reverse. The states that an item
// passes from acceptance to the output register, with the result side ready:
// - a start, or a tick after the timeline has finished: from acceptance straight
//   to the output state, which loads the result.
// - a tick that ends a pass skips the divide: difference, compare, output.
// - any other tick: difference, compare, then the 16-step bit-serial divide of
//   elapsed time by the duration, a final state and output. In seconds, a
//   multiply and a shift stage for the divide by 1000 come between difference
//   and compare for either kind of tick.
// One item is in work at a time. The output register lets the next item be
// accepted while a result waits. A stalled result side can hold the next item in
// its output state. Configuration writes are always ready and take effect at once.
module animation_timeline_sequencer_core import ats_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ats_in_if.sink    i_in,
    ats_out_if.source o_out,
    ats_cfg_if.sink   i_cfg
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    ats_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    ats_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_op        (i_in.op),
        .i_now_ms    (i_in.now_ms),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_progress  (o_out.progress),
        .o_computed  (o_out.computed),
        .o_reversing (o_out.reversing),
        .o_finished  (o_out.finished)
    );

endmodule

### rtl/ats_checker.sv
// Port-level checks for the timeline sequencer, bound to the top level.
// Depends on ats_pkg and animation_timeline_sequencer_core.
module ats_checker import ats_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [PROG_W-1:0] i_progress,
    input logic              i_computed
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_progress)))
        else $error("result changed while stalled");

    a_prog_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_progress <= ONE_Q16))
        else $error("progress above 1.0");

    a_uncomputed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_computed) |-> (i_progress == '0))
        else $error("progress nonzero on uncomputed item");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("item accepted while another is in work");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind animation_timeline_sequencer_core ats_checker u_ats_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_progress  (o_out.progress),
    .i_computed  (o_out.computed)
);

### bench/tb_animation_timeline_sequencer_core.sv
// Self-checking bench for animation_timeline_sequencer_core: directed and random
// start/tick items under random idling, checked against a cycle-free timeline model.
// Depends on ats_pkg and the channel interfaces in ats_if.sv.
`timescale 1ns / 1ps

module tb_animation_timeline_sequencer_core;
    import ats_pkg::*;

    localparam int unsigned MS_PER_SEC  = 1000;
    localparam logic [1:0]  TU_SPARE    = 2'd3;   // unused code, behaves as seconds
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          RAND_ITEMS  = 1450;

    typedef struct packed {
        logic [PROG_W-1:0] progress;
        logic              computed;
        logic              reversing;
        logic              finished;
    } t_result;

    // Shadow of the timeline state plus the queue of results still owed by the block.
    class t_scoreboard;
        logic [1:0]         time_unit;
        logic [DUR_W-1:0]   duration;
        logic [REP_W-1:0]   repeat_count;
        logic               auto_reverse;
        logic [STAMP_W-1:0] frames;
        logic [STAMP_W-1:0] origin;
        logic [REP_W-1:0]   repeats_left;
        logic               restart_pending;
        logic               reversed;
        logic               done;
        t_result            due_results[$];
        int                 errors;

        function new();
            time_unit       = TIME_UNIT_RST;
            duration        = DURATION_RST;
            repeat_count    = REPEAT_RST;
            auto_reverse    = 1'b0;
            frames          = '0;
            origin          = '0;
            repeats_left    = REPEAT_RST;
            restart_pending = 1'b0;
            reversed        = 1'b0;
            done            = 1'b0;
            errors          = 0;
        endfunction

        task report(input string msg);
            errors++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        function void set_reg(input logic [1:0] idx, input logic [DUR_W-1:0] value);
            case (idx)
                CFG_TIME_UNIT:    time_unit    = value[1:0];
                CFG_DURATION:     duration     = value;
                CFG_REPEAT_COUNT: repeat_count = value[REP_W-1:0];
                CFG_AUTO_REVERSE: auto_reverse = value[0];
                default: ;
            endcase
        endfunction

        // true when the last pass has just completed; zero means run forever
        function bit count_pass();
            if (repeats_left != '0) begin
                repeats_left = repeats_left - 8'd1;
                return repeats_left == '0;
            end
            return 1'b0;
        endfunction

        function void note_item(input logic op, input logic [STAMP_W-1:0] stamp);
            logic [STAMP_W-1:0] elapsed;
            logic [63:0]        scaled;
            logic [PROG_W-1:0]  frac;
            logic               pass_end;
            t_result            r;
            r = '0;
            if (op == OP_START) begin
                frames          = '0;
                origin          = stamp;
                repeats_left    = repeat_count;
                restart_pending = 1'b0;
                reversed        = 1'b0;
                done            = 1'b0;
                due_results.insert(due_results.size(), r);
                return;
            end
            if (restart_pending) begin
                restart_pending = 1'b0;
                frames          = '0;
                origin          = stamp;
            end else if (done) begin
                r.reversing = reversed;
                r.finished  = 1'b1;
                due_results.insert(due_results.size(), r);
                return;
            end
            frames = frames + 32'd1;
            case (time_unit)
                TU_FRAMES: elapsed = frames;
                TU_MS:     elapsed = stamp - origin;
                default:   elapsed = (stamp - origin) / MS_PER_SEC;
            endcase
            pass_end = (elapsed >= {16'b0, duration});
            if (pass_end) begin
                frac = ONE_Q16;
            end else begin
                scaled = {16'b0, elapsed, 16'b0};
                scaled = scaled / {48'b0, duration};
                frac   = scaled[PROG_W-1:0];
            end
            if (reversed) begin
                frac = ONE_Q16 - frac;
            end
            if (pass_end) begin
                if (auto_reverse) begin
                    restart_pending = 1'b1;
                    if (reversed) begin
                        if (count_pass()) done = 1'b1;
                        reversed = 1'b0;
                    end else begin
                        reversed = 1'b1;
                    end
                end else if (count_pass()) begin
                    done = 1'b1;
                end else begin
                    restart_pending = 1'b1;
                end
            end
            r.progress  = frac;
            r.computed  = 1'b1;
            r.reversing = reversed;
            r.finished  = done;
            due_results.insert(due_results.size(), r);
        endfunction

        task check_result(input t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                report($sformatf("result with nothing owed, progress %0d", got.progress));
                return;
            end
            want = due_results.pop_front();
            if (got.progress !== want.progress)
                report($sformatf("progress %0d, want %0d", got.progress, want.progress));
            if (got.computed !== want.computed)
                report($sformatf("computed %b, want %b", got.computed, want.computed));
            if (got.reversing !== want.reversing)
                report($sformatf("reversing %b, want %b", got.reversing, want.reversing));
            if (got.finished !== want.finished)
                report($sformatf("finished %b, want %b", got.finished, want.finished));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ats_in_if  in_if ();
    ats_out_if out_if ();
    ats_cfg_if cfg_if ();

    animation_timeline_sequencer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    t_scoreboard sb;
    bit no_idle;
    int hold_requests;
    int cycles;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: checks, random stalls, and the long hold-off on request
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                sb.check_result({out_if.progress, out_if.computed,
                                 out_if.reversing, out_if.finished});
            end
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= no_idle || ($urandom_range(99) >= 14);
            end
        end
    end

    task automatic send_item(input logic op, input logic [STAMP_W-1:0] stamp);
        if (!no_idle && $urandom_range(99) < 14) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.op     <= op;
        in_if.now_ms <= stamp;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_item(op, stamp);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DUR_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.set_reg(idx, value);
    endtask

    // registers change only with the block idle
    task automatic set_config(input logic [1:0] tu, input logic [DUR_W-1:0] dur,
                              input logic [REP_W-1:0] rep, input logic ar);
        drain();
        write_reg(CFG_TIME_UNIT, {14'b0, tu});
        write_reg(CFG_DURATION, dur);
        write_reg(CFG_REPEAT_COUNT, {8'b0, rep});
        write_reg(CFG_AUTO_REVERSE, {15'b0, ar});
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        logic [1:0]         tu;
        logic [DUR_W-1:0]   dur;
        logic [REP_W-1:0]   rep;
        logic               ar;
        logic [STAMP_W-1:0] cur;
        logic [STAMP_W-1:0] step;
        int                 phase;
        int                 len;
        int                 pick;
        int                 rand_items;

        sb            = new();
        no_idle       = 1'b0;
        hold_requests = 0;
        cycles        = 0;
        i_rst_n       <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.op      <= OP_START;
        in_if.now_ms  <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.index  <= CFG_TIME_UNIT;
        cfg_if.data   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, ticks before any start, then wrap of the stamp
        send_item(OP_TICK, 32'd150);
        send_item(OP_TICK, 32'd300);
        send_item(OP_TICK, 32'd5000);
        send_item(OP_START, 32'hFFFF_FF00);
        send_item(OP_TICK, 32'h0000_002C);

        // frames, auto-reverse: forward pass, backward pass, then finished
        set_config(TU_FRAMES, 16'd2, 8'd1, 1'b1);
        send_item(OP_START, 32'd0);
        repeat (5) send_item(OP_TICK, 32'd0);

        // auto-reverse cleared mid-reverse: stays mirrored, repeats forever
        set_config(TU_FRAMES, 16'd2, 8'd0, 1'b1);
        send_item(OP_START, 32'd0);
        repeat (2) send_item(OP_TICK, 32'd0);
        set_config(TU_FRAMES, 16'd2, 8'd0, 1'b0);
        repeat (3) send_item(OP_TICK, 32'd0);

        // spare time-unit code counts whole seconds
        set_config(TU_SPARE, 16'd2, 8'd1, 1'b0);
        send_item(OP_START, 32'd7000);
        send_item(OP_TICK, 32'd8999);
        send_item(OP_TICK, 32'd9000);

        // zero duration ends every pass at once
        set_config(TU_MS, 16'd0, 8'd3, 1'b0);
        send_item(OP_START, 32'd0);
        send_item(OP_TICK, 32'd0);

        // widest duration and repeat count
        set_config(TU_MS, 16'hFFFF, 8'hFF, 1'b1);
        send_item(OP_START, 32'd0);
        send_item(OP_TICK, 32'd65534);
        send_item(OP_TICK, 32'hFFFF_FFFF);

        phase      = 0;
        rand_items = 0;
        cur        = $urandom();
        while (rand_items < RAND_ITEMS) begin
            tu = 2'($urandom_range(3));
            case (tu)
                TU_FRAMES: dur = DUR_W'(($urandom_range(9) == 0) ? $urandom_range(1, 65535)
                                                                 : $urandom_range(1, 8));
                TU_MS: begin
                    pick = $urandom_range(19);
                    dur  = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'd1
                                       : DUR_W'($urandom_range(2, 2000));
                end
                default: dur = ($urandom_range(19) == 0) ? 16'd0
                                                         : DUR_W'($urandom_range(1, 4));
            endcase
            pick = $urandom_range(9);
            rep  = (pick == 0) ? 8'hFF : (pick == 1) ? REP_W'($urandom_range(0, 255))
                                                    : REP_W'($urandom_range(0, 4));
            ar   = 1'($urandom_range(1));
            set_config(tu, dur, rep, ar);
            no_idle = (phase >= 3 && phase <= 5);
            // result side holds off while items keep coming
            if (phase == 1) hold_requests++;
            len = $urandom_range(30, 90);
            for (int k = 0; k < len; k++) begin
                pick = (k == 0) ? 0 : $urandom_range(99);
                if (pick < 8) begin
                    case ($urandom_range(3))
                        0:       cur = $urandom();
                        1:       cur = 32'hFFFF_FFFF - $urandom_range(0, 3000);
                        default: ;
                    endcase
                    send_item(OP_START, cur);
                end else if (pick < 11) begin
                    send_item(OP_TICK, $urandom());
                end else begin
                    case (tu)
                        TU_FRAMES: step = $urandom_range(0, 50);
                        TU_MS:     step = $urandom_range(0, dur / 3 + 1);
                        default:   step = $urandom_range(0, 1300);
                    endcase
                    cur = cur + step;
                    send_item(OP_TICK, cur);
                end
                rand_items++;
                if ($urandom_range(199) == 0) drain();
            end
            phase++;
        end

        no_idle = 1'b0;
        drain();
        repeat (40) @(posedge i_clk);
        if (sb.due_results.size() != 0) sb.report("results still owed at end of run");
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### animation_timeline_sequencer_core.f
rtl/ats_pkg.sv
rtl/ats_if.sv
rtl/ats_ctrl.sv
rtl/ats_dp.sv
rtl/animation_timeline_sequencer_core.sv
rtl/ats_checker.sv
bench/tb_animation_timeline_sequencer_core.sv
